// ===== hdl/gregorian_day_difference_defines.svh =====
// ---------------------------------------------------------------------------
// Gregorian day difference assertion macros
// Shared assertion macros for the day difference block.
// ---------------------------------------------------------------------------
`ifndef GREGORIAN_DAY_DIFFERENCE_DEFINES_SVH
`define GREGORIAN_DAY_DIFFERENCE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// The consequent must hold in the same cycle as the antecedent.
`define GDD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define GDD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define GDD_ASSERT_SAME(label, clk, rst, ante, cons)
`define GDD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/gdd_pkg.sv =====
// ---------------------------------------------------------------------------
// Gregorian day difference package
// Widths, tables and shared types for the day difference block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package gdd_pkg;

   localparam int YEAR_W  = 14;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int YS_W    = 15;  // shifted year, year + 400 fits
   localparam int DOY_W   = 9;   // day of the March-based year
   localparam int DN_W    = 23;  // day number
   localparam int CNT_W   = 22;  // result count
   localparam int PROD_W  = 26;  // reciprocal product
   localparam int Q_W     = 9;   // quotient by 25

   // Reciprocal of 25 scaled by 2^17, exact for operands below 43690.
   localparam logic [12:0] RECIP25    = 13'd5243;
   localparam int          RECIP_SH   = 17;
   localparam logic [14:0] YEAR_SHIFT = 15'd400;
   localparam logic [DN_W-1:0] DAYS_PER_YEAR = 23'd365;

   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

   // Stage enables handed from the top level to each lane.
   typedef struct packed {
      logic s1;
      logic s2;
   } gdd_lane_en_type;

   // What one lane found for one date.
   typedef struct packed {
      logic [DN_W-1:0] day_num;
      logic            ok;
   } gdd_day_type;

   // Days before the month in a year that starts in March.
   function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
      logic [DOY_W-1:0] r;
      case (m)
         4'd1:    r = 9'd306;
         4'd2:    r = 9'd337;
         4'd3:    r = 9'd0;
         4'd4:    r = 9'd31;
         4'd5:    r = 9'd61;
         4'd6:    r = 9'd92;
         4'd7:    r = 9'd122;
         4'd8:    r = 9'd153;
         4'd9:    r = 9'd184;
         4'd10:   r = 9'd214;
         4'd11:   r = 9'd245;
         4'd12:   r = 9'd275;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

   // Length of the month in a common year.
   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
      logic [DAY_W-1:0] r;
      case (m)
         4'd2:                   r = 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
         default:                r = 5'd31;
      endcase
      return r;
   endfunction

endpackage

// ===== hdl/gdd_lane.sv =====
// ---------------------------------------------------------------------------
// Gregorian day difference date lane
// Turns one date into a day number and a validity flag in two stages.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module gdd_lane (
   input  logic                          clock,
   input  gdd_pkg::gdd_lane_en_type      en,
   input  logic [gdd_pkg::YEAR_W-1:0]    year,
   input  logic [gdd_pkg::MONTH_W-1:0]   month,
   input  logic [gdd_pkg::DAY_W-1:0]     day,
   output gdd_pkg::gdd_day_type          result
);

   // Stage one: shifted year, day of year and both reciprocal products.
   logic [gdd_pkg::YS_W-1:0]    ys_in, ys_ff;
   logic [gdd_pkg::DOY_W-1:0]   doy_in, doy_ff;
   logic [gdd_pkg::PROD_W-1:0]  pys_in, pys_ff;
   logic [gdd_pkg::PROD_W-1:0]  py_in, py_ff;
   logic [gdd_pkg::YEAR_W-1:0]  year_ff;
   logic [gdd_pkg::MONTH_W-1:0] month_ff;
   logic [gdd_pkg::DAY_W-1:0]   day_ff;

   always_comb begin
      ys_in  = {1'b0, year} + gdd_pkg::YEAR_SHIFT
               - {14'd0, (month <= gdd_pkg::MONTH_FEB)};
      doy_in = gdd_pkg::days_before(month) + {4'd0, day} - 9'd1;
      pys_in = {13'd0, ys_in[gdd_pkg::YS_W-1:2]} * {13'd0, gdd_pkg::RECIP25};
      py_in  = {14'd0, year[gdd_pkg::YEAR_W-1:2]} * {13'd0, gdd_pkg::RECIP25};
   end

   always_ff @(posedge clock) begin
      if (en.s1) begin
         ys_ff    <= ys_in;
         doy_ff   <= doy_in;
         pys_ff   <= pys_in;
         py_ff    <= py_in;
         year_ff  <= year;
         month_ff <= month;
         day_ff   <= day;
      end
   end

   // Stage two: day number and the check of the date against its month.
   logic [gdd_pkg::Q_W-1:0]  q100, q400, qy;
   logic [12:0]              qy25;
   logic                     leap;
   logic [gdd_pkg::DAY_W-1:0] len;
   gdd_pkg::gdd_day_type     res_in, res_ff;

   always_comb begin
      q100 = pys_ff[gdd_pkg::RECIP_SH +: gdd_pkg::Q_W];
      q400 = q100 >> 2;
      qy   = py_ff[gdd_pkg::RECIP_SH +: gdd_pkg::Q_W];
      qy25 = {4'd0, qy} * 13'd25;
      // Divisible by 4, and either not by 100 or also by 400.
      leap = (year_ff[1:0] == 2'd0)
             && ((qy25 != {1'b0, year_ff[gdd_pkg::YEAR_W-1:2]}) || (qy[1:0] == 2'd0));
      len  = gdd_pkg::month_len(month_ff);
      if (month_ff == gdd_pkg::MONTH_FEB && leap) begin
         len = 5'd29;
      end
      res_in.ok = (month_ff != 4'd0) && (month_ff <= gdd_pkg::MONTH_DEC)
                  && (day_ff != 5'd0) && (day_ff <= len);
      res_in.day_num = {8'd0, ys_ff} * gdd_pkg::DAYS_PER_YEAR
                       + {10'd0, ys_ff[gdd_pkg::YS_W-1:2]}
                       - {14'd0, q100} + {14'd0, q400}
                       + {14'd0, doy_ff};
   end

   always_ff @(posedge clock) begin
      if (en.s2) begin
         res_ff <= res_in;
      end
   end

   assign result = res_ff;

endmodule

// ===== hdl/gdd_merge.sv =====
// ---------------------------------------------------------------------------
// Gregorian day difference merge stage
// Combines the two lanes into an absolute, saturated day count.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module gdd_merge (
   input  logic                        clock,
   input  logic                        en,
   input  gdd_pkg::gdd_day_type        first,
   input  gdd_pkg::gdd_day_type        second,
   output logic [gdd_pkg::CNT_W-1:0]   day_count,
   output logic                        invalid_date
);

   logic [gdd_pkg::DN_W-1:0]  diff;
   logic [gdd_pkg::CNT_W-1:0] count_in, count_ff;
   logic                      invalid_in, invalid_ff;

   // Absolute difference, clipped to the count width; zero on a bad date.
   always_comb begin
      if (first.day_num >= second.day_num) begin
         diff = first.day_num - second.day_num;
      end else begin
         diff = second.day_num - first.day_num;
      end
      invalid_in = !(first.ok && second.ok);
      if (invalid_in) begin
         count_in = '0;
      end else if (diff[gdd_pkg::DN_W-1]) begin
         count_in = '1;
      end else begin
         count_in = diff[gdd_pkg::CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         count_ff   <= count_in;
         invalid_ff <= invalid_in;
      end
   end

   assign day_count    = count_ff;
   assign invalid_date = invalid_ff;

endmodule

// ===== hdl/gregorian_day_difference.sv =====
// ---------------------------------------------------------------------------
// Gregorian day difference
// Absolute number of days between two proleptic Gregorian dates.
// ---------------------------------------------------------------------------
// An item on the req_ channel carries two dates; the rsp_ channel returns one
// item per request with the day count and an invalid flag. A date with a bad
// month, a zero day or a day past the end of its month gives an invalid flag
// and a count of zero. Counts above the 22-bit range saturate.
// Two date lanes run side by side, each two stages deep (reciprocal products,
// then the day number), and a merge stage forms the absolute difference.
// An accepted item passes through the v1_ff, v2_ff and v3_ff stages in order
// and rsp_valid is v3_ff. Throughput is one item per cycle while rsp_ready is
// high, as every stage hands its item on in the same cycle it takes a new one.
// Each stage holds its item while the one after it is full and stalled, so
// req_ready drops only when all three stages hold items and rsp_ready is low.
// Reset clears the stage valid bits; no result is pending after reset.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "gregorian_day_difference_defines.svh"

module gregorian_day_difference (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [gdd_pkg::YEAR_W-1:0]    req_first_year,
   input  logic [gdd_pkg::MONTH_W-1:0]   req_first_month,
   input  logic [gdd_pkg::DAY_W-1:0]     req_first_day,
   input  logic [gdd_pkg::YEAR_W-1:0]    req_second_year,
   input  logic [gdd_pkg::MONTH_W-1:0]   req_second_month,
   input  logic [gdd_pkg::DAY_W-1:0]     req_second_day,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [gdd_pkg::CNT_W-1:0]     rsp_day_count,
   output logic                          rsp_invalid_date
);

   logic v1_ff, v2_ff, v3_ff;
   logic ready1, ready2, ready3;
   gdd_pkg::gdd_lane_en_type lane_en;
   gdd_pkg::gdd_day_type     first_res, second_res;

   // A stage takes a new item when it is empty or its item moves on.
   assign ready3 = !v3_ff || rsp_ready;
   assign ready2 = !v2_ff || ready3;
   assign ready1 = !v1_ff || ready2;
   assign lane_en = '{s1: ready1, s2: ready2};

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (ready1) begin
            v1_ff <= req_valid;
         end
         if (ready2) begin
            v2_ff <= v1_ff;
         end
         if (ready3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   // One lane for each date.
   gdd_lane u_lane_first (
      .clock  (clock),
      .en     (lane_en),
      .year   (req_first_year),
      .month  (req_first_month),
      .day    (req_first_day),
      .result (first_res)
   );

   gdd_lane u_lane_second (
      .clock  (clock),
      .en     (lane_en),
      .year   (req_second_year),
      .month  (req_second_month),
      .day    (req_second_day),
      .result (second_res)
   );

   gdd_merge u_merge (
      .clock        (clock),
      .en           (ready3),
      .first        (first_res),
      .second       (second_res),
      .day_count    (rsp_day_count),
      .invalid_date (rsp_invalid_date)
   );

   assign req_ready = ready1;
   assign rsp_valid = v3_ff;

   // An invalid result always carries a zero count.
   `GDD_ASSERT_SAME(a_invalid_zero, clock, reset, v3_ff && rsp_invalid_date, rsp_day_count == '0)
   // Reset leaves no result pending.
   `GDD_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !v3_ff && !v2_ff && !v1_ff)
   // An accepted item always lands in the first stage.
   `GDD_ASSERT_NEXT(a_accept_stage1, clock, reset, req_valid && req_ready, v1_ff)
   // A stalled result is not overwritten by the stage behind it.
   `GDD_ASSERT_NEXT(a_stall_holds, clock, reset, v3_ff && !rsp_ready && v2_ff, v3_ff && v2_ff)

endmodule
